// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon block
// Coordinate widths, status codes, payload structs and the edge record.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int CoordBits       = 24;
  localparam int CrossBits       = 9;
  localparam int StatusBits      = 2;
  localparam int MaxEdgesDefault = 256;

  localparam logic [CrossBits-1:0] CrossMax = {CrossBits{1'b1}};

  localparam logic signed [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

  // request kinds
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // result status codes
  localparam logic [StatusBits-1:0] StatStored   = 2'd0;
  localparam logic [StatusBits-1:0] StatVertical = 2'd1;
  localparam logic [StatusBits-1:0] StatFull     = 2'd2;
  localparam logic [StatusBits-1:0] StatQuery    = 2'd3;

  typedef struct packed {
    logic                 req_type;
    logic                 first_edge;
    logic [CoordBits-1:0] x_a;
    logic [CoordBits-1:0] y_a;
    logic [CoordBits-1:0] x_b;
    logic [CoordBits-1:0] y_b;
  } in_item_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic                  inside_res;
    logic [CrossBits-1:0]  crossings;
  } out_item_t;

  // one stored edge, left end first
  typedef struct packed {
    logic [CoordBits-1:0] lx;
    logic [CoordBits-1:0] ly;
    logic [CoordBits-1:0] rx;
    logic [CoordBits-1:0] ry;
  } edge_t;

  // control from the sequencer to the scan pipeline
  typedef struct packed {
    logic clear;       // restart the crossing count
    logic data_valid;  // edge table read data valid this cycle
  } scan_ctrl_t;

endpackage

// ===== rtl/pip_ram.sv =====
// ----------------------------------------------------------------------------
// pip_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pip_scan.sv =====
// ----------------------------------------------------------------------------
// pip_scan: edge crossing pipeline
// Span check and differences, two signed products, compare and count.
// ----------------------------------------------------------------------------
module pip_scan #(
  parameter int MaxEdges = pip_pkg::MaxEdgesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pip_pkg::scan_ctrl_t               ctrl_i,
  input  pip_pkg::edge_t                    edge_i,
  input  logic [pip_pkg::CoordBits-1:0]     px_i,
  input  logic [pip_pkg::CoordBits-1:0]     py_i,
  output logic                              busy_o,
  output logic [$clog2(MaxEdges+1)-1:0]     count_o
);
  import pip_pkg::*;

  localparam int CntW  = $clog2(MaxEdges + 1);
  localparam int DiffW = CoordBits + 1;
  localparam int ProdW = 2 * DiffW;

  // stage A: span test and differences
  logic                    a_vld_q, a_vld_d;
  logic                    a_hit_q, a_hit_d;
  logic signed [DiffW-1:0] dxp_q, dxp_d;  // px - lx
  logic signed [DiffW-1:0] dyr_q, dyr_d;  // ry - ly
  logic signed [DiffW-1:0] dyp_q, dyp_d;  // py - ly
  logic signed [DiffW-1:0] dxr_q, dxr_d;  // rx - lx
  // stage B: products
  logic                    b_vld_q, b_vld_d;
  logic signed [ProdW-1:0] pl_q, pl_d;
  logic signed [ProdW-1:0] pr_q, pr_d;
  logic [CntW-1:0]         cnt_q, cnt_d;

  always_comb begin
    a_vld_d = ctrl_i.data_valid;
    a_hit_d = ($signed(edge_i.lx) <= $signed(px_i)) && ($signed(px_i) < $signed(edge_i.rx));
    dxp_d   = {px_i[CoordBits-1], px_i} - {edge_i.lx[CoordBits-1], edge_i.lx};
    dyr_d   = {edge_i.ry[CoordBits-1], edge_i.ry} - {edge_i.ly[CoordBits-1], edge_i.ly};
    dyp_d   = {py_i[CoordBits-1], py_i} - {edge_i.ly[CoordBits-1], edge_i.ly};
    dxr_d   = {edge_i.rx[CoordBits-1], edge_i.rx} - {edge_i.lx[CoordBits-1], edge_i.lx};

    b_vld_d = a_vld_q && a_hit_q;
    pl_d    = dxp_q * dyr_q;
    pr_d    = dyp_q * dxr_q;

    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (b_vld_q && (pl_q > pr_q)) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      a_vld_q <= a_vld_d;
      b_vld_q <= b_vld_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_hit_q <= a_hit_d;
    dxp_q   <= dxp_d;
    dyr_q   <= dyr_d;
    dyp_q   <= dyp_d;
    dxr_q   <= dxr_d;
    pl_q    <= pl_d;
    pr_q    <= pr_d;
  end

  assign busy_o  = a_vld_q || b_vld_q;
  assign count_o = cnt_q;

endmodule

// ===== rtl/point_in_polygon_crossing_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test: crossing-number point-in-polygon test
// Edge table in RAM, bounding box registers, scan sequencer, output register.
// ----------------------------------------------------------------------------
// Load polygon edges (req_type 0), then query points (req_type 1). A load
// with first_edge set starts a new polygon. Each non-vertical edge is stored
// left end first in an edge table RAM of MaxEdges entries; every load but a
// non-vertical one into a full table widens an inclusive bounding box. A load
// into a full table is dropped (status 2). A query outside the box answers at
// once; otherwise the sequencer reads the table one edge per cycle and a
// pipeline counts edges whose span covers px and that lie above the point,
// compared exactly as two signed products. An odd count means inside; the
// reported count saturates at 511. Timing: one item is in work at a time. A
// load, or a query that misses the box or finds an empty table, goes from
// the input transfer through StPush into the output register, and the block
// then takes the next input transfer. A query that scans first reads the
// table through the single read port (one edge per cycle); each edge then
// passes the RAM read, two compare stages and the final count check, and
// the result is loaded through StPush into the output register. The result
// sits in an output register, so the next input transfer is taken while it
// waits downstream; the block only stalls when it has a new result and the
// old one is unread.
// The table needs no clearing after reset; only entries below the edge
// count are read.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test #(
  parameter int MaxEdges = pip_pkg::MaxEdgesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pip_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pip_pkg::out_item_t out_item_o
);
  import pip_pkg::*;

  localparam int IdxW  = $clog2(MaxEdges);
  localparam int CntW  = $clog2(MaxEdges + 1);
  localparam int WideW = (CntW > CrossBits) ? CntW : CrossBits;

  localparam logic [1:0] StIdle = 2'd0;  // waiting for a transfer
  localparam logic [1:0] StScan = 2'd1;  // walking the edge table
  localparam logic [1:0] StPush = 2'd2;  // handing the result to the output reg

  typedef logic signed [CoordBits-1:0] coord_t;

  function automatic coord_t smin3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  function automatic coord_t smax3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  coord_t          bmin_x_q, bmin_x_d, bmax_x_q, bmax_x_d;
  coord_t          bmin_y_q, bmin_y_d, bmax_y_q, bmax_y_d;
  coord_t          px_q, px_d, py_q, py_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_vld_q;
  out_item_t       res_q, res_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  // edge table port
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  edge_t           ram_wdata;
  logic            rd_en;
  edge_t           ram_rdata;

  // scan pipeline
  scan_ctrl_t      scan_ctrl;
  logic            scan_busy;
  logic [CntW-1:0] scan_cnt;
  logic [WideW-1:0] cnt_wide;

  // load decode, on the state as left by an optional clear
  logic            in_fire;
  coord_t          xa, ya, xb, yb;
  logic [CntW-1:0] base_count;
  coord_t          base_min_x, base_max_x, base_min_y, base_max_y;
  logic            vertical, full, in_box;

  assign in_fire = in_valid_i && in_ready_o;
  assign xa = coord_t'(in_item_i.x_a);
  assign ya = coord_t'(in_item_i.y_a);
  assign xb = coord_t'(in_item_i.x_b);
  assign yb = coord_t'(in_item_i.y_b);

  assign base_count = in_item_i.first_edge ? '0 : count_q;
  assign base_min_x = in_item_i.first_edge ? CoordMax : bmin_x_q;
  assign base_max_x = in_item_i.first_edge ? CoordMin : bmax_x_q;
  assign base_min_y = in_item_i.first_edge ? CoordMax : bmin_y_q;
  assign base_max_y = in_item_i.first_edge ? CoordMin : bmax_y_q;

  assign vertical = (xa == xb);
  assign full     = (base_count >= CntW'(MaxEdges));
  assign in_box   = (xa >= bmin_x_q) && (xa <= bmax_x_q) &&
                    (ya >= bmin_y_q) && (ya <= bmax_y_q);

  assign cnt_wide = WideW'(scan_cnt);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    bmin_x_d    = bmin_x_q;
    bmax_x_d    = bmax_x_q;
    bmin_y_d    = bmin_y_q;
    bmax_y_d    = bmax_y_q;
    px_d        = px_q;
    py_d        = py_q;
    rd_idx_d    = rd_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    scan_ctrl   = '0;
    rd_en       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = base_count[IdxW-1:0];
    if (xa < xb) begin
      ram_wdata = '{lx: in_item_i.x_a, ly: in_item_i.y_a, rx: in_item_i.x_b, ry: in_item_i.y_b};
    end else begin
      ram_wdata = '{lx: in_item_i.x_b, ly: in_item_i.y_b, rx: in_item_i.x_a, ry: in_item_i.y_a};
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          res_d = '0;
          if (in_item_i.req_type == ReqLoad) begin
            state_d = StPush;
            count_d = base_count;
            bmin_x_d = base_min_x;
            bmax_x_d = base_max_x;
            bmin_y_d = base_min_y;
            bmax_y_d = base_max_y;
            if (vertical || !full) begin
              bmin_x_d = smin3(base_min_x, xa, xb);
              bmax_x_d = smax3(base_max_x, xa, xb);
              bmin_y_d = smin3(base_min_y, ya, yb);
              bmax_y_d = smax3(base_max_y, ya, yb);
            end
            if (vertical) begin
              res_d.status = StatVertical;
            end else if (full) begin
              res_d.status = StatFull;
            end else begin
              res_d.status = StatStored;
              ram_we  = 1'b1;
              count_d = base_count + CntW'(1);
            end
          end else begin
            res_d.status    = StatQuery;
            px_d            = xa;
            py_d            = ya;
            rd_idx_d        = '0;
            scan_ctrl.clear = 1'b1;
            state_d = (in_box && (count_q != '0)) ? StScan : StPush;
          end
        end
      end
      StScan: begin
        rd_en = (rd_idx_q < count_q);
        scan_ctrl.data_valid = rd_vld_q;
        if (rd_en) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end else if (!rd_vld_q && !scan_busy) begin
          // pipeline drained, count is final
          res_d.inside_res = scan_cnt[0];
          res_d.crossings  = (cnt_wide > WideW'(CrossMax)) ? CrossMax
                                                            : cnt_wide[CrossBits-1:0];
          state_d = StPush;
        end
      end
      StPush: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      bmin_x_q    <= CoordMax;
      bmax_x_q    <= CoordMin;
      bmin_y_q    <= CoordMax;
      bmax_y_q    <= CoordMin;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bmin_x_q    <= bmin_x_d;
      bmax_x_q    <= bmax_x_d;
      bmin_y_q    <= bmin_y_d;
      bmax_y_q    <= bmax_y_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  pip_ram #(
    .Width($bits(edge_t)),
    .Depth(MaxEdges)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_idx_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  pip_scan #(
    .MaxEdges(MaxEdges)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .edge_i (ram_rdata),
    .px_i   (px_q),
    .py_i   (py_q),
    .busy_o (scan_busy),
    .count_o(scan_cnt)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // table writes only happen on a load transfer
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StIdle) && in_fire)
    else $error("edge table written outside a load");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEdges))
    else $error("edge count beyond table depth");

  // the table must not change under a running scan
  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |=> $stable(count_q))
    else $error("edge count changed during scan");

  a_scan_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (state_q == StScan) && (rd_idx_q < count_q))
    else $error("table read past edge count");

  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPush) && (!out_valid_q || out_ready_i) |=> out_valid_o)
    else $error("result not presented after push");
`endif

endmodule
